// File: hw/rtl/tga_pkg.sv
// Shared types and constants for the TGA run-length image decoder.
`timescale 1ns / 1ps
`default_nettype none

package tga_pkg;

  typedef enum logic [1:0] {
    PH_HALT = 2'd0,
    PH_HEAD = 2'd1,
    PH_DATA = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR_OK  = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_HDR_BAD = 2'd2
  } kind_e;

  localparam logic [4:0] HdrPatLen   = 5'd12;
  localparam logic [4:0] HdrPosType  = 5'd2;
  localparam logic [4:0] HdrPosWLo   = 5'd12;
  localparam logic [4:0] HdrPosWHi   = 5'd13;
  localparam logic [4:0] HdrPosHLo   = 5'd14;
  localparam logic [4:0] HdrPosHHi   = 5'd15;
  localparam logic [4:0] HdrPosDepth = 5'd16;
  localparam logic [4:0] HdrPosLast  = 5'd17;

  localparam logic [7:0] TypeRle    = 8'd10;
  localparam logic [7:0] TypeRaw    = 8'd2;
  localparam logic [7:0] DepthAlpha = 8'd32;
  localparam logic [7:0] DepthPlain = 8'd24;

  localparam logic [7:0] MaxRepeat = 8'd128;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_t;

  typedef struct packed {
    kind_e       result_kind;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic        has_alpha;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        last;
  } out_t;

endpackage

`default_nettype wire

// File: hw/rtl/tga_dec_core.sv
// Decoder state registers and per-byte header and pixel decode logic.
`timescale 1ns / 1ps
`default_nettype none

module tga_dec_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         accept_i,
  input  wire tga_pkg::in_t item_i,
  output logic              res_valid_o,
  output tga_pkg::out_t     res_o
);

  tga_pkg::phase_e phase_q, phase_d, cur_phase;
  logic [4:0]  hpos_q, hpos_d, cur_hpos;
  logic        rle_q, rle_d, cur_rle;
  logic [15:0] width_q, width_d, cur_width;
  logic [15:0] height_q, height_d, cur_height;
  logic        alpha_q, alpha_d, cur_alpha;
  logic [31:0] left_q, left_d, cur_left;
  logic        run_q, run_d, cur_run;
  logic [7:0]  pkt_q, pkt_d, cur_pkt;
  logic [31:0] pix_q, pix_d, cur_pix;
  logic [1:0]  bip_q, bip_d, cur_bip;

  logic [7:0]  b;
  logic [31:0] area;
  logic [31:0] pix_acc;
  logic [1:0]  bip_next;
  logic [1:0]  need;
  logic [7:0]  rep;
  logic [31:0] left_after;
  logic        empty;

  always_comb begin
    b = item_i.data_byte;

    if (item_i.first_byte) begin
      cur_phase  = tga_pkg::PH_HEAD;
      cur_hpos   = '0;
      cur_rle    = 1'b0;
      cur_width  = '0;
      cur_height = '0;
      cur_alpha  = 1'b0;
      cur_left   = '0;
      cur_run    = 1'b0;
      cur_pkt    = '0;
      cur_pix    = '0;
      cur_bip    = '0;
    end else begin
      cur_phase  = phase_q;
      cur_hpos   = hpos_q;
      cur_rle    = rle_q;
      cur_width  = width_q;
      cur_height = height_q;
      cur_alpha  = alpha_q;
      cur_left   = left_q;
      cur_run    = run_q;
      cur_pkt    = pkt_q;
      cur_pix    = pix_q;
      cur_bip    = bip_q;
    end

    phase_d  = cur_phase;
    hpos_d   = cur_hpos;
    rle_d    = cur_rle;
    width_d  = cur_width;
    height_d = cur_height;
    alpha_d  = cur_alpha;
    left_d   = cur_left;
    run_d    = cur_run;
    pkt_d    = cur_pkt;
    pix_d    = cur_pix;
    bip_d    = cur_bip;

    area       = cur_width * cur_height;
    empty      = (cur_width == '0) || (cur_height == '0);
    pix_acc    = cur_pix | ({24'b0, b} << {cur_bip, 3'b000});
    bip_next   = cur_bip + 2'd1;
    need       = cur_alpha ? 2'd0 : 2'd3;
    rep        = 8'd1;
    left_after = cur_left;

    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (cur_phase)
      tga_pkg::PH_HEAD: begin
        hpos_d = cur_hpos + 5'd1;
        if (cur_hpos < tga_pkg::HdrPatLen) begin
          if (cur_hpos == tga_pkg::HdrPosType) begin
            if (b == tga_pkg::TypeRle) begin
              rle_d = 1'b1;
            end else if (b == tga_pkg::TypeRaw) begin
              rle_d = 1'b0;
            end else begin
              phase_d = tga_pkg::PH_HALT;
              res_valid_o = 1'b1;
              res_o.result_kind = tga_pkg::KIND_HDR_BAD;
            end
          end else if (b != 8'd0) begin
            phase_d = tga_pkg::PH_HALT;
            res_valid_o = 1'b1;
            res_o.result_kind = tga_pkg::KIND_HDR_BAD;
          end
        end else if (cur_hpos == tga_pkg::HdrPosWLo) begin
          width_d = {8'b0, b};
        end else if (cur_hpos == tga_pkg::HdrPosWHi) begin
          width_d = {b, cur_width[7:0]};
        end else if (cur_hpos == tga_pkg::HdrPosHLo) begin
          height_d = {8'b0, b};
        end else if (cur_hpos == tga_pkg::HdrPosHHi) begin
          height_d = {b, cur_height[7:0]};
        end else if (cur_hpos == tga_pkg::HdrPosDepth) begin
          if (b == tga_pkg::DepthAlpha) begin
            alpha_d = 1'b1;
          end else if (b == tga_pkg::DepthPlain) begin
            alpha_d = 1'b0;
          end else begin
            phase_d = tga_pkg::PH_HALT;
            res_valid_o = 1'b1;
            res_o.result_kind = tga_pkg::KIND_HDR_BAD;
          end
        end else begin
          left_d  = area;
          pkt_d   = '0;
          run_d   = 1'b0;
          pix_d   = '0;
          bip_d   = '0;
          phase_d = empty ? tga_pkg::PH_DONE : tga_pkg::PH_DATA;
          res_valid_o        = 1'b1;
          res_o.result_kind  = tga_pkg::KIND_HDR_OK;
          res_o.out_width    = cur_width;
          res_o.out_height   = cur_height;
          res_o.has_alpha    = cur_alpha;
          res_o.last         = empty;
        end
      end
      tga_pkg::PH_DATA: begin
        if (cur_rle && (cur_pkt == '0)) begin
          run_d = b[7];
          pkt_d = {1'b0, b[6:0]} + 8'd1;
        end else if (bip_next != need) begin
          pix_d = pix_acc;
          bip_d = bip_next;
        end else begin
          pix_d = '0;
          bip_d = '0;
          if (cur_rle && cur_run) begin
            rep   = ({24'b0, cur_pkt} < cur_left) ? cur_pkt : cur_left[7:0];
            pkt_d = '0;
          end else begin
            rep = 8'd1;
            if (cur_rle) begin
              pkt_d = cur_pkt - 8'd1;
            end
          end
          left_after = cur_left - {24'b0, rep};
          left_d     = left_after;
          if (left_after == '0) begin
            phase_d = tga_pkg::PH_DONE;
          end
          res_valid_o        = 1'b1;
          res_o.result_kind  = tga_pkg::KIND_PIXEL;
          res_o.has_alpha    = cur_alpha;
          res_o.pixel_value  = pix_acc;
          res_o.repeat_count = rep;
          res_o.last         = (left_after == '0);
        end
      end
      tga_pkg::PH_HALT, tga_pkg::PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (!accept_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tga_pkg::PH_HALT;
      hpos_q   <= '0;
      rle_q    <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      alpha_q  <= 1'b0;
      left_q   <= '0;
      run_q    <= 1'b0;
      pkt_q    <= '0;
      pix_q    <= '0;
      bip_q    <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      hpos_q   <= hpos_d;
      rle_q    <= rle_d;
      width_q  <= width_d;
      height_q <= height_d;
      alpha_q  <= alpha_d;
      left_q   <= left_d;
      run_q    <= run_d;
      pkt_q    <= pkt_d;
      pix_q    <= pix_d;
      bip_q    <= bip_d;
    end
  end

  a_data_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tga_pkg::PH_DATA) |-> (left_q != '0))
    else $error("data phase with no pixels left");

  a_head_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == tga_pkg::PH_HEAD) |-> (hpos_q <= tga_pkg::HdrPosLast))
    else $error("header position past descriptor byte");

  a_run_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.result_kind == tga_pkg::KIND_PIXEL)) |->
      ((res_o.repeat_count != 8'd0) && (res_o.repeat_count <= tga_pkg::MaxRepeat)))
    else $error("pixel run count out of range");

  a_pixel_byte_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!alpha_q && (phase_q == tga_pkg::PH_DATA)) |-> (bip_q != 2'd3))
    else $error("byte index beyond 24-bit pixel");

endmodule

`default_nettype wire

// File: hw/rtl/tga_out_buf.sv
// Two-entry result register with skid slot between decode and output channel.
`timescale 1ns / 1ps
`default_nettype none

module tga_out_buf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire tga_pkg::out_t push_data_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tga_pkg::out_t      out_data_o
);

  logic          main_valid_q;
  tga_pkg::out_t main_data_q;
  logic          skid_valid_q;
  tga_pkg::out_t skid_data_q;
  logic          pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_data_q <= skid_data_q;
      end else if (push_i) begin
        main_data_q <= push_data_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_data_q <= push_data_i;
      end else begin
        main_data_q <= push_data_i;
      end
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid slot holds data while output slot is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("result pushed into full buffer");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && main_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("stalled result not captured in skid slot");

endmodule

`default_nettype wire

// File: hw/rtl/tga_rle_image_decoder.sv
// Top level of the TGA run-length image decoder: byte input, pixel-run output.
// A decoded result is registered in the output buffer before it reaches out_valid_o.
// Throughput: one byte per cycle while in_stall_o is low; decode is combinational.
// A two-entry output buffer takes one more result during an output stall.
// Reset: all decoder state clears; the block ignores bytes until first_byte.
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_image_decoder (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire tga_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tga_pkg::out_t      out_data_o
);

  logic          accept;
  logic          res_valid;
  tga_pkg::out_t res;
  logic          buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  tga_dec_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tga_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_result_needs_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> accept)
    else $error("result without accepted byte");

  a_stall_means_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending output");

  a_result_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_o)
    else $error("result lost before output");

endmodule

`default_nettype wire
